// ===== rtl/spa_pkg.sv =====
package spa_pkg;

  localparam int unsigned POOL_BYTES        = 1048576;
  localparam int unsigned MAX_BUCKETS       = 16;
  localparam int unsigned HDR_BYTES         = 16;
  localparam int unsigned MIN_PAYLOAD_BYTES = 16;

  localparam int unsigned INFO_DEPTH = 65536;
  localparam int unsigned INFO_W     = 22;
  localparam int unsigned GRAN_W     = 16;
  localparam int unsigned BKT_W      = 4;
  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned POOL_W     = 21;
  localparam int unsigned LIVE_W     = 16;

  localparam logic [4:0]  RST_NUM_BUCKETS = 5'd12;
  localparam logic [10:0] RST_POOL_KIB    = 11'd1024;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_POP_RD,
    ST_SPLIT_RD,
    ST_SPLIT,
    ST_FREE_RD
  } state_t;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_TOO_LARGE   = 3'd1,
    STS_EXHAUSTED   = 3'd2,
    STS_DOUBLE_FREE = 3'd3,
    STS_INVALID     = 3'd4,
    STS_IN_USE      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  localparam logic [1:0] BS_UNUSED    = 2'd0;
  localparam logic [1:0] BS_USED      = 2'd1;
  localparam logic [1:0] BS_FREE_MORE = 2'd2;
  localparam logic [1:0] BS_FREE_LAST = 2'd3;

  localparam logic CFG_NUM_BUCKETS = 1'b0;
  localparam logic CFG_POOL_KIB    = 1'b1;

  typedef struct packed {
    logic [GRAN_W-1:0] succ;
    logic [BKT_W-1:0]  bkt;
    logic [1:0]        st;
  } info_t;

  function automatic logic [ADDR_W-1:0] payload_of(input logic [BKT_W-1:0] b);
    payload_of = ADDR_W'(MIN_PAYLOAD_BYTES) << b;
  endfunction

  function automatic logic [POOL_W-1:0] size_of(input logic [BKT_W-1:0] b);
    size_of = POOL_W'(payload_of(b)) + POOL_W'(HDR_BYTES);
  endfunction

endpackage

// ===== rtl/spa_ram.sv =====
module spa_ram import spa_pkg::*; #(
  parameter int unsigned WIDTH = INFO_W,
  parameter int unsigned DEPTH = INFO_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/segregated_pool_allocator.sv =====
// Channel        | Ports                                         | Transaction
// ---------------+-----------------------------------------------+---------------------------
// command in     | start, busy, in_cmd, in_alloc_size, in_free_*  | start high while busy low
// result out     | out_valid, out_status, out_address, out_usable*| one cycle with out_valid
// configuration  | cfg_we, cfg_index, cfg_wdata                   | any cycle with cfg_we high
//
// A refused allocation, a rejected free address, a refresh with live blocks and the unused
// command answer in the cycle after acceptance. Carving from the pool top also answers at once;
// popping a free list, and any free that reaches the block memory, wait for the registered
// read of the block memory.
// A split pops the larger block, then writes one further piece per step, up to 16384 pieces.
// After reset and after a refresh that reinitialises, a clearing pass writes all 65536
// block entries, one a cycle, with busy high; the refresh result follows the pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module segregated_pool_allocator import spa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_cmd,
  input  logic [23:0]         in_alloc_size,
  input  logic [ADDR_W-1:0]   in_free_address,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [ADDR_W-1:0]   out_address,
  output logic [ADDR_W-1:0]   out_usable_size,
  output logic [BKT_W-1:0]    out_bucket,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_wdata
);

  // Control state and configuration.
  state_t              state_r, state_nxt;
  logic [GRAN_W-1:0]   sweep_r, sweep_nxt;
  logic                pend_r, pend_nxt;
  logic [4:0]          nb_r, nb_nxt;
  logic [10:0]         kib_r, kib_nxt;
  logic [4:0]          act_nb_r, act_nb_nxt;
  logic [POOL_W-1:0]   act_pool_r, act_pool_nxt;

  // Free list heads: a valid bit and a header granule per bucket.
  logic [MAX_BUCKETS-1:0] hv_r, hv_nxt;
  logic [GRAN_W-1:0]      hg_r [MAX_BUCKETS];
  logic [GRAN_W-1:0]      hg_nxt [MAX_BUCKETS];

  logic [POOL_W-1:0]   top_r, top_nxt;
  logic [LIVE_W-1:0]   live_r, live_nxt;

  // Working registers of the command in flight.
  logic [BKT_W-1:0]    bi_r, bi_nxt;
  logic [BKT_W-1:0]    bj_r, bj_nxt;
  logic [GRAN_W-1:0]   g_r, g_nxt;
  logic [POOL_W-1:0]   off_r, off_nxt;
  logic [ADDR_W-1:0]   pin_r, pin_nxt;

  // Result registers.
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_address_r, out_address_nxt;
  logic [ADDR_W-1:0]   out_usable_r, out_usable_nxt;
  logic [BKT_W-1:0]    out_bucket_r, out_bucket_nxt;

  // Block memory port.
  logic                ram_we;
  logic [GRAN_W-1:0]   ram_waddr, ram_raddr;
  logic [INFO_W-1:0]   ram_wdata, ram_rdata;
  info_t               rinfo;

  logic                accept;
  logic                fit_found, jf;
  logic [BKT_W-1:0]    fit_idx, jidx;
  logic [POOL_W-1:0]   sz_fit, room, carve_h;
  logic                pop_hit, carve_ok;
  logic [ADDR_W-1:0]   free_h;
  logic                free_bad;
  logic [BKT_W-1:0]    hd_idx;
  logic [GRAN_W-1:0]   hd_gran;
  logic                hd_valid;
  logic [POOL_W-1:0]   sz_s, szj, base_addr, cur_addr, nxt_off, nxt_addr, first_addr;
  logic                nxt_exist, first_exist;
  logic [LIVE_W-1:0]   live_inc;

  function automatic logic [POOL_W-1:0] pool_of(input logic [10:0] kib);
    logic [POOL_W-1:0] pb;
    pb = {kib, 10'b0};
    pool_of = (pb > POOL_W'(POOL_BYTES)) ? POOL_W'(POOL_BYTES) : pb;
  endfunction

  function automatic logic [4:0] nb_of(input logic [4:0] nb);
    if (nb == 5'd0) begin
      nb_of = 5'd1;
    end else if (nb > 5'(MAX_BUCKETS)) begin
      nb_of = 5'(MAX_BUCKETS);
    end else begin
      nb_of = nb;
    end
  endfunction

  spa_ram #(
    .WIDTH (INFO_W),
    .DEPTH (INFO_DEPTH)
  ) u_info (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rinfo  = info_t'(ram_rdata);
  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  // Smallest fitting bucket, and the next larger bucket with a non-empty list.
  always_comb begin
    fit_found = 1'b0;
    fit_idx   = '0;
    for (int b = 0; b < MAX_BUCKETS; b++) begin
      if (!fit_found && (5'(b) < act_nb_r) &&
          (24'(size_of(BKT_W'(b))) >= in_alloc_size)) begin
        fit_found = 1'b1;
        fit_idx   = BKT_W'(b);
      end
    end
  end

  always_comb begin
    jf   = 1'b0;
    jidx = '0;
    for (int b = 0; b < MAX_BUCKETS; b++) begin
      if (!jf && (BKT_W'(b) > fit_idx) && (5'(b) < act_nb_r) && hv_r[b]) begin
        jf   = 1'b1;
        jidx = BKT_W'(b);
      end
    end
  end

  assign sz_fit   = size_of(fit_idx);
  assign room     = (act_pool_r > top_r) ? (act_pool_r - top_r) : '0;
  assign carve_ok = (room > sz_fit);
  assign carve_h  = room - sz_fit;
  assign pop_hit  = hv_r[fit_idx];

  assign free_h   = in_free_address - ADDR_W'(HDR_BYTES);
  assign free_bad = (in_free_address < ADDR_W'(HDR_BYTES)) || (free_h[3:0] != 4'd0) ||
                    ({1'b0, free_h} >= act_pool_r);

  // One read of the head table per cycle.
  always_comb begin
    if (state_r == ST_FREE_RD) begin
      hd_idx = rinfo.bkt;
    end else if (pop_hit) begin
      hd_idx = fit_idx;
    end else begin
      hd_idx = jidx;
    end
  end
  assign hd_gran  = hg_r[hd_idx];
  assign hd_valid = hv_r[hd_idx];

  // Split arithmetic: pieces of the requested bucket cut upward from the larger header.
  assign sz_s        = size_of(bi_r);
  assign szj         = size_of(bj_r);
  assign base_addr   = {1'b0, g_r, 4'b0};
  assign cur_addr    = base_addr + off_r;
  assign nxt_off     = off_r + sz_s;
  assign nxt_addr    = base_addr + nxt_off;
  assign nxt_exist   = (nxt_off + sz_s) <= szj;
  assign first_addr  = base_addr + sz_s;
  assign first_exist = {sz_s[POOL_W-2:0], 1'b0} <= szj;

  assign live_inc = (live_r == '1) ? live_r : live_r + LIVE_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_ALLOC: begin
              if (fit_found) begin
                if (pop_hit) begin
                  state_nxt = ST_POP_RD;
                end else if (!carve_ok && jf) begin
                  state_nxt = ST_SPLIT_RD;
                end
              end
            end
            CMD_FREE: begin
              if (!free_bad) begin
                state_nxt = ST_FREE_RD;
              end
            end
            CMD_REFRESH: begin
              if (live_r == '0) begin
                state_nxt = ST_SWEEP;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POP_RD:   state_nxt = ST_IDLE;
      ST_FREE_RD:  state_nxt = ST_IDLE;
      ST_SPLIT_RD: state_nxt = first_exist ? ST_SPLIT : ST_IDLE;
      ST_SPLIT:    state_nxt = nxt_exist ? ST_SPLIT : ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory accesses and results.
  always_comb begin
    sweep_nxt    = sweep_r;
    pend_nxt     = pend_r;
    nb_nxt       = nb_r;
    kib_nxt      = kib_r;
    act_nb_nxt   = act_nb_r;
    act_pool_nxt = act_pool_r;
    hv_nxt       = hv_r;
    hg_nxt       = hg_r;
    top_nxt      = top_r;
    live_nxt     = live_r;
    bi_nxt       = bi_r;
    bj_nxt       = bj_r;
    g_nxt        = g_r;
    off_nxt      = off_r;
    pin_nxt      = pin_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_address_nxt = out_address_r;
    out_usable_nxt  = out_usable_r;
    out_bucket_nxt  = out_bucket_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    case (state_r)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = '0;
        sweep_nxt = sweep_r + GRAN_W'(1);
        if (sweep_r == '1) begin
          if (pend_r) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STS_OK;
            out_address_nxt = '0;
            out_usable_nxt  = '0;
            out_bucket_nxt  = '0;
          end
          pend_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          out_address_nxt = '0;
          out_usable_nxt  = '0;
          out_bucket_nxt  = '0;
          out_status_nxt  = STS_OK;
          case (cmd_t'(in_cmd))
            CMD_ALLOC: begin
              bi_nxt = fit_idx;
              if (!fit_found) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_TOO_LARGE;
              end else if (pop_hit) begin
                ram_raddr = hd_gran;
                g_nxt     = hd_gran;
              end else if (carve_ok) begin
                // Carve a fresh block downward from the pool top.
                ram_we          = 1'b1;
                ram_waddr       = carve_h[19:4];
                ram_wdata       = {GRAN_W'(0), fit_idx, BS_USED};
                top_nxt         = top_r + sz_fit;
                live_nxt        = live_inc;
                out_valid_nxt   = 1'b1;
                out_address_nxt = {carve_h[19:4], 4'b0} + ADDR_W'(HDR_BYTES);
                out_usable_nxt  = payload_of(fit_idx);
                out_bucket_nxt  = fit_idx;
              end else if (jf) begin
                ram_raddr = hd_gran;
                g_nxt     = hd_gran;
                bj_nxt    = jidx;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_EXHAUSTED;
              end
            end
            CMD_FREE: begin
              pin_nxt = in_free_address;
              if (free_bad) begin
                out_valid_nxt   = 1'b1;
                out_status_nxt  = STS_INVALID;
                out_address_nxt = in_free_address;
              end else begin
                ram_raddr = free_h[19:4];
                g_nxt     = free_h[19:4];
              end
            end
            CMD_REFRESH: begin
              if (live_r != '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_IN_USE;
              end else begin
                hv_nxt = '0;
                for (int b = 0; b < MAX_BUCKETS; b++) begin
                  hg_nxt[b] = '0;
                end
                top_nxt      = '0;
                act_nb_nxt   = nb_of(nb_r);
                act_pool_nxt = pool_of(kib_r);
                pend_nxt     = 1'b1;
                sweep_nxt    = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_POP_RD: begin
        hv_nxt[bi_r] = (rinfo.st == BS_FREE_MORE);
        hg_nxt[bi_r] = (rinfo.st == BS_FREE_MORE) ? rinfo.succ : '0;
        ram_we          = 1'b1;
        ram_waddr       = g_r;
        ram_wdata       = {GRAN_W'(0), bi_r, BS_USED};
        live_nxt        = live_inc;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = STS_OK;
        out_address_nxt = {g_r, 4'b0} + ADDR_W'(HDR_BYTES);
        out_usable_nxt  = payload_of(bi_r);
        out_bucket_nxt  = bi_r;
      end
      ST_SPLIT_RD: begin
        // Pop the larger block; its first piece is marked used at once and is the one handed out.
        hv_nxt[bj_r] = (rinfo.st == BS_FREE_MORE);
        hg_nxt[bj_r] = (rinfo.st == BS_FREE_MORE) ? rinfo.succ : '0;
        ram_we    = 1'b1;
        ram_waddr = g_r;
        ram_wdata = {GRAN_W'(0), bi_r, BS_USED};
        live_nxt  = live_inc;
        off_nxt   = sz_s;
        if (first_exist) begin
          hv_nxt[bi_r] = 1'b1;
          hg_nxt[bi_r] = first_addr[19:4];
        end else begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STS_OK;
          out_address_nxt = {g_r, 4'b0} + ADDR_W'(HDR_BYTES);
          out_usable_nxt  = payload_of(bi_r);
          out_bucket_nxt  = bi_r;
        end
      end
      ST_SPLIT: begin
        // Each remaining piece links to the one above it; the highest ends the list.
        ram_we    = 1'b1;
        ram_waddr = cur_addr[19:4];
        ram_wdata = nxt_exist ? {nxt_addr[19:4], bi_r, BS_FREE_MORE}
                              : {GRAN_W'(0), bi_r, BS_FREE_LAST};
        off_nxt   = nxt_off;
        if (!nxt_exist) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STS_OK;
          out_address_nxt = {g_r, 4'b0} + ADDR_W'(HDR_BYTES);
          out_usable_nxt  = payload_of(bi_r);
          out_bucket_nxt  = bi_r;
        end
      end
      ST_FREE_RD: begin
        out_valid_nxt   = 1'b1;
        out_address_nxt = pin_r;
        out_usable_nxt  = '0;
        out_bucket_nxt  = '0;
        if (rinfo.st == BS_UNUSED) begin
          out_status_nxt = STS_INVALID;
        end else if (rinfo.st != BS_USED) begin
          out_status_nxt = STS_DOUBLE_FREE;
          out_usable_nxt = payload_of(rinfo.bkt);
          out_bucket_nxt = rinfo.bkt;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = g_r;
          ram_wdata = {hd_gran, rinfo.bkt, hd_valid ? BS_FREE_MORE : BS_FREE_LAST};
          hv_nxt[rinfo.bkt] = 1'b1;
          hg_nxt[rinfo.bkt] = g_r;
          if (live_r != '0) begin
            live_nxt = live_r - LIVE_W'(1);
          end
          out_status_nxt = STS_OK;
          out_usable_nxt = payload_of(rinfo.bkt);
          out_bucket_nxt = rinfo.bkt;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase

    // A register write takes effect at once while nothing has been carved from the pool.
    if (cfg_we) begin
      if (cfg_index == CFG_NUM_BUCKETS) begin
        nb_nxt = cfg_wdata[4:0];
      end else begin
        kib_nxt = cfg_wdata;
      end
      if (top_r == '0) begin
        act_nb_nxt   = nb_of((cfg_index == CFG_NUM_BUCKETS) ? cfg_wdata[4:0] : nb_r);
        act_pool_nxt = pool_of((cfg_index == CFG_POOL_KIB) ? cfg_wdata : kib_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      nb_r        <= RST_NUM_BUCKETS;
      kib_r       <= RST_POOL_KIB;
      act_nb_r    <= nb_of(RST_NUM_BUCKETS);
      act_pool_r  <= pool_of(RST_POOL_KIB);
      hv_r        <= '0;
      for (int b = 0; b < MAX_BUCKETS; b++) begin
        hg_r[b] <= '0;
      end
      top_r       <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      pend_r      <= pend_nxt;
      nb_r        <= nb_nxt;
      kib_r       <= kib_nxt;
      act_nb_r    <= act_nb_nxt;
      act_pool_r  <= act_pool_nxt;
      hv_r        <= hv_nxt;
      hg_r        <= hg_nxt;
      top_r       <= top_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bi_r          <= bi_nxt;
    bj_r          <= bj_nxt;
    g_r           <= g_nxt;
    off_r         <= off_nxt;
    pin_r         <= pin_nxt;
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
    out_usable_r  <= out_usable_nxt;
    out_bucket_r  <= out_bucket_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address     = out_address_r;
  assign out_usable_size = out_usable_r;
  assign out_bucket      = out_bucket_r;

endmodule

// ===== rtl/spa_chk.sv =====
module spa_chk import spa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input logic [2:0]        out_status,
  input logic [ADDR_W-1:0] out_address,
  input logic [ADDR_W-1:0] out_usable_size,
  input logic [BKT_W-1:0]  out_bucket
);

  // Reset always starts the clearing pass.
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // Refused allocations and refused refreshes carry no block.
  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_TOO_LARGE || out_status == STS_EXHAUSTED ||
                  out_status == STS_IN_USE)
    |-> (out_address == '0 && out_usable_size == '0 && out_bucket == '0))
    else $error("refusal carries block fields");

  // A granted or freed block's size follows its bucket.
  a_size_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_OK && out_usable_size != '0
    |-> out_usable_size == (ADDR_W'(MIN_PAYLOAD_BYTES) << out_bucket))
    else $error("usable size does not match bucket");

  // Block payload addresses sit on the granule grid.
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_OK && out_usable_size != '0
    |-> out_address[3:0] == 4'd0)
    else $error("payload address not aligned");

endmodule

bind segregated_pool_allocator spa_chk u_spa_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_address     (out_address),
  .out_usable_size (out_usable_size),
  .out_bucket      (out_bucket)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the segregated pool allocator.
// Commands are driven on the falling edge and results are sampled on the rising edge.
// A behavioural copy of the allocator state (free list heads, block table, pool top and
// live count) predicts every result at the moment its command transaction is accepted.
// The monitor compares each result strobe with the oldest prediction, field by field.
module tb_top;
  import spa_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [2:0]        st;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] usable;
    logic [BKT_W-1:0]  bkt;
  } result_t;

  typedef struct {
    cmd_t              cmd;
    logic [23:0]       size;
    logic [ADDR_W-1:0] faddr;
    bit                typed;
    status_t           st;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] usable;
    logic [BKT_W-1:0]  bkt;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = CMD_NOP;
  logic [23:0]       in_alloc_size = '0;
  logic [ADDR_W-1:0] in_free_address = '0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [ADDR_W-1:0] out_address;
  logic [ADDR_W-1:0] out_usable_size;
  logic [BKT_W-1:0]  out_bucket;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_NUM_BUCKETS;
  logic [10:0]       cfg_wdata = '0;

  always #5 clk = ~clk;

  segregated_pool_allocator dut (.*);

  // Behavioural copy of the allocator state.
  logic [INFO_W-1:0] blk_table [INFO_DEPTH];
  logic [16:0]       list_head [MAX_BUCKETS];
  int unsigned       top_bytes, live_count;
  int unsigned       reg_buckets, reg_kib, eff_buckets, eff_pool;

  // Blocks the stimulus knows to be live, and a history of released ones for double frees.
  logic [ADDR_W-1:0] live_q [$];
  logic [ADDR_W-1:0] released_q [$];

  result_t pending_q [$];
  int      n_mismatch = 0;
  int      n_items = 0;
  int      n_results = 0;
  int      n_splits = 0;
  int      sts_seen [6];
  int      idle_cycles = 0;

  function automatic int unsigned block_bytes(int unsigned b);
    return (MIN_PAYLOAD_BYTES << b) + HDR_BYTES;
  endfunction

  function automatic void take_registers();
    eff_buckets = (reg_buckets < 1) ? 1 :
                  (reg_buckets > MAX_BUCKETS) ? MAX_BUCKETS : reg_buckets;
    eff_pool    = (reg_kib * 1024 > POOL_BYTES) ? POOL_BYTES : reg_kib * 1024;
  endfunction

  function automatic void wipe_pool();
    foreach (blk_table[k]) blk_table[k] = '0;
    foreach (list_head[k]) list_head[k] = '0;
    top_bytes  = 0;
    live_count = 0;
    live_q.delete();
    released_q.delete();
  endfunction

  function automatic void push_block(logic [15:0] g, logic [3:0] b);
    logic [1:0] st;
    st = list_head[b][16] ? BS_FREE_MORE : BS_FREE_LAST;
    blk_table[g] = {list_head[b][15:0], b, st};
    list_head[b] = {1'b1, g};
  endfunction

  function automatic logic [15:0] pop_block(logic [3:0] b);
    logic [15:0]       g;
    logic [INFO_W-1:0] e;
    g = list_head[b][15:0];
    e = blk_table[g];
    list_head[b] = (e[1:0] == BS_FREE_MORE) ? {1'b1, e[21:6]} : 17'd0;
    blk_table[g] = {16'd0, b, BS_USED};
    return g;
  endfunction

  function automatic void drop_live(logic [ADDR_W-1:0] a);
    foreach (live_q[k]) begin
      if (live_q[k] == a) begin
        live_q.delete(k);
        return;
      end
    end
  endfunction

  function automatic result_t serve_alloc(logic [23:0] req);
    result_t     r;
    int unsigned i, j, sz, room, base, pieces;
    logic [15:0] g;
    r = '{STS_OK, '0, '0, '0};
    for (i = 0; i < eff_buckets; i++)
      if (block_bytes(i) >= req) break;
    if (i >= eff_buckets) begin
      r.st = STS_TOO_LARGE;
      return r;
    end
    sz = block_bytes(i);
    if (list_head[i][16]) begin
      g = pop_block(BKT_W'(i));
    end else begin
      room = (eff_pool > top_bytes) ? eff_pool - top_bytes : 0;
      if (room > sz) begin
        top_bytes += sz;
        g = 16'((room - sz) >> 4);
        blk_table[g] = {16'd0, 4'(i), BS_USED};
      end else begin
        for (j = i + 1; j < eff_buckets; j++)
          if (list_head[j][16]) break;
        if (j >= eff_buckets) begin
          r.st = STS_EXHAUSTED;
          return r;
        end
        // Cut the larger block into pieces of this bucket from its header upward.
        base   = int'(pop_block(BKT_W'(j))) << 4;
        pieces = block_bytes(j) / sz;
        for (int k = pieces - 1; k >= 0; k--)
          push_block(16'((base + k * sz) >> 4), BKT_W'(i));
        g = pop_block(BKT_W'(i));
        n_splits++;
      end
    end
    if (live_count < 16'hFFFF) live_count++;
    r.addr   = ADDR_W'((int'(g) << 4) + HDR_BYTES);
    r.usable = ADDR_W'(MIN_PAYLOAD_BYTES << i);
    r.bkt    = BKT_W'(i);
    live_q.push_back(r.addr);
    return r;
  endfunction

  function automatic result_t serve_free(logic [ADDR_W-1:0] p);
    result_t           r;
    int unsigned       h;
    logic [15:0]       g;
    logic [INFO_W-1:0] e;
    r = '{STS_INVALID, p, '0, '0};
    if (p < HDR_BYTES) return r;
    h = p - HDR_BYTES;
    if (h[3:0] != 0 || h >= eff_pool) return r;
    g = 16'(h >> 4);
    e = blk_table[g];
    if (e[1:0] == BS_UNUSED) return r;
    r.bkt    = e[5:2];
    r.usable = ADDR_W'(MIN_PAYLOAD_BYTES << e[5:2]);
    if (e[1:0] != BS_USED) begin
      r.st = STS_DOUBLE_FREE;
      return r;
    end
    push_block(g, e[5:2]);
    if (live_count > 0) live_count--;
    r.st = STS_OK;
    drop_live(p);
    released_q.push_back(p);
    if (released_q.size() > 32) void'(released_q.pop_front());
    return r;
  endfunction

  function automatic result_t model_command(cmd_t c, logic [23:0] sz, logic [ADDR_W-1:0] fa);
    result_t r;
    r = '{STS_OK, '0, '0, '0};
    case (c)
      CMD_ALLOC: r = serve_alloc(sz);
      CMD_FREE:  r = serve_free(fa);
      CMD_REFRESH: begin
        if (live_count != 0) begin
          r.st = STS_IN_USE;
        end else begin
          wipe_pool();
          take_registers();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drives one command and waits for its transaction. Start stays high afterwards so that
  // back-to-back commands need no gap; pause() lowers it.
  task automatic issue(cmd_t c, logic [23:0] sz, logic [ADDR_W-1:0] fa, bit typed = 0,
                       result_t want = '{STS_OK, '0, '0, '0});
    result_t r;
    @(negedge clk);
    start           <= 1'b1;
    in_cmd          <= c;
    in_alloc_size   <= sz;
    in_free_address <= fa;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = model_command(c, sz, fa);
    pending_q.push_back(typed ? want : r);
    n_items++;
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits until every outstanding result has arrived and the block has gone idle.
  task automatic settle();
    pause(0);
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] val);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_NUM_BUCKETS) reg_buckets = val[4:0];
    else reg_kib = val;
    if (top_bytes == 0) take_registers();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Releases every live block so that a refresh can reinitialise the pool.
  task automatic drain_and_refresh();
    while (live_q.size() != 0) issue(CMD_FREE, '0, live_q[0]);
    issue(CMD_REFRESH, '0, '0);
    settle();
  endtask

  function automatic logic [23:0] pick_size();
    int unsigned b, r;
    r = $urandom_range(0, 99);
    b = $urandom_range(0, (eff_buckets > 5) ? 4 : eff_buckets - 1);
    if (r < 65) return 24'($urandom_range(0, block_bytes(b)));
    if (r < 75) return 24'($urandom_range(0, block_bytes(eff_buckets - 1)));
    if (r < 85) return 24'($urandom());
    return 24'(block_bytes(b) + $urandom_range(0, 1));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_wild_address();
    if ($urandom_range(0, 1)) return ADDR_W'($urandom());
    return ADDR_W'($urandom_range(0, (eff_pool + 64) >> 4) << 4);
  endfunction

  // One phase of random traffic, mostly well-formed allocate and free pairs.
  task automatic random_traffic(int count);
    int burst, r;
    burst = $urandom_range(1, 20);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 48 || (r < 78 && live_q.size() == 0)) begin
        issue(CMD_ALLOC, pick_size(), ADDR_W'($urandom()));
      end else if (r < 78) begin
        issue(CMD_FREE, 24'($urandom()), live_q[$urandom_range(0, live_q.size() - 1)]);
      end else if (r < 85 && released_q.size() != 0) begin
        issue(CMD_FREE, 24'($urandom()),
              released_q[$urandom_range(0, released_q.size() - 1)]);
      end else if (r < 93) begin
        issue(CMD_FREE, 24'($urandom()), pick_wild_address());
      end else if (r < 97 || live_q.size() == 0) begin
        issue(CMD_NOP, 24'($urandom()), ADDR_W'($urandom()));
      end else begin
        // Live blocks exist, so the refresh is refused and costs no clearing pass.
        issue(CMD_REFRESH, 24'($urandom()), ADDR_W'($urandom()));
      end
      if (--burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 8));
      end
    end
  endtask

  // Directed opening on the reset configuration: twelve buckets over a 1 MiB pool.
  row_t directed [] = '{
    '{CMD_ALLOC,   24'd0,        20'd0,       1, STS_OK,          20'hFFFF0, 20'd16, 4'd0},
    '{CMD_ALLOC,   24'hFFFFFF,   20'd0,       1, STS_TOO_LARGE,   20'd0,     20'd0,  4'd0},
    '{CMD_ALLOC,   24'd32,       20'd0,       0, STS_OK,          20'd0,     20'd0,  4'd0},
    '{CMD_ALLOC,   24'd33,       20'd0,       0, STS_OK,          20'd0,     20'd0,  4'd0},
    '{CMD_ALLOC,   24'd32784,    20'd0,       0, STS_OK,          20'd0,     20'd0,  4'd0},
    '{CMD_ALLOC,   24'd32785,    20'd0,       1, STS_TOO_LARGE,   20'd0,     20'd0,  4'd0},
    '{CMD_FREE,    24'd0,        20'd0,       1, STS_INVALID,     20'd0,     20'd0,  4'd0},
    '{CMD_FREE,    24'd0,        20'd15,      1, STS_INVALID,     20'd15,    20'd0,  4'd0},
    '{CMD_FREE,    24'd0,        20'hFFFFF,   1, STS_INVALID,     20'hFFFFF, 20'd0,  4'd0},
    '{CMD_FREE,    24'd0,        20'd24,      1, STS_INVALID,     20'd24,    20'd0,  4'd0},
    '{CMD_FREE,    24'd0,        20'd32,      1, STS_INVALID,     20'd32,    20'd0,  4'd0},
    '{CMD_FREE,    24'd0,        20'hFFFF0,   1, STS_OK,          20'hFFFF0, 20'd16, 4'd0},
    '{CMD_FREE,    24'd0,        20'hFFFF0,   1, STS_DOUBLE_FREE, 20'hFFFF0, 20'd16, 4'd0},
    '{CMD_ALLOC,   24'd20,       20'd0,       1, STS_OK,          20'hFFFF0, 20'd16, 4'd0},
    '{CMD_REFRESH, 24'd0,        20'd0,       1, STS_IN_USE,      20'd0,     20'd0,  4'd0},
    '{CMD_NOP,     24'hFFFFFF,   20'hFFFFF,   1, STS_OK,          20'd0,     20'd0,  4'd0}
  };

  // Register settings per phase, extremes included; odd phases write before the refresh.
  logic [4:0]  phase_buckets [] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd16, 5'd12};
  logic [10:0] phase_kib     [] = '{11'd1, 11'd2047, 11'd4, 11'd2, 11'd64, 11'd1, 11'd1024};

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_t want;
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("ERROR: result with nothing outstanding: st=%0d addr=%h",
                   out_status, out_address);
      end else begin
        want = pending_q.pop_front();
        n_results++;
        if (out_status < 6) sts_seen[out_status]++;
        if (out_status !== want.st || out_address !== want.addr ||
            out_usable_size !== want.usable || out_bucket !== want.bkt) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("ERROR: result %0d expected st=%0d addr=%h use=%h bkt=%0d",
                     n_results, want.st, want.addr, want.usable, want.bkt);
            $display("       got st=%0d addr=%h use=%h bkt=%0d",
                     out_status, out_address, out_usable_size, out_bucket);
          end
        end
      end
    end
  end

  // Watchdog: the clearing pass and the largest split stay well inside the limit.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** segregated_pool_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    reg_buckets = RST_NUM_BUCKETS;
    reg_kib     = RST_POOL_KIB;
    wipe_pool();
    take_registers();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k])
      issue(directed[k].cmd, directed[k].size, directed[k].faddr, directed[k].typed,
            '{directed[k].st, directed[k].addr, directed[k].usable, directed[k].bkt});
    drain_and_refresh();

    foreach (phase_buckets[p]) begin
      if (p % 2) begin
        // Written with blocks carved, so the new values wait for the refresh.
        write_reg(CFG_NUM_BUCKETS, 11'(phase_buckets[p]));
        write_reg(CFG_POOL_KIB, phase_kib[p]);
        drain_and_refresh();
      end else begin
        // Written on an empty pool, so the new values apply at once.
        drain_and_refresh();
        write_reg(CFG_POOL_KIB, phase_kib[p]);
        write_reg(CFG_NUM_BUCKETS, 11'(phase_buckets[p]));
      end
      random_traffic(65);
      settle();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d commands and %0d results over %0d register settings, %0d splits.",
             n_items, n_results, phase_buckets.size() + 1, n_splits);
    $display("Status counts ok/large/exhausted/double/invalid/in-use: %0d/%0d/%0d/%0d/%0d/%0d",
             sts_seen[0], sts_seen[1], sts_seen[2], sts_seen[3], sts_seen[4], sts_seen[5]);
    if (n_mismatch == 0 && pending_q.size() == 0) begin
      $display("** segregated_pool_allocator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, pending_q.size());
      $display("** segregated_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule
